>>> design/tkds_pkg.sv
// Shared types and constants for the three-key descending sorter.
`timescale 1ns / 1ps

package tkds_pkg;

	// Defaults of the top-level parameters
	localparam int DEF_MAX_ITEMS = 64;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int DEF_ID_WIDTH  = 16;

	// Depth of the command queue between front and back (power of two)
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [15:0]        item_id;
		logic signed [31:0] primary_weight;
		logic signed [31:0] secondary_weight;
		logic signed [31:0] tertiary_weight;
		logic               is_last;
	} load_req_t;

	typedef struct packed {
		logic [15:0]        sorted_id;
		logic signed [31:0] out_primary;
		logic signed [31:0] out_secondary;
		logic signed [31:0] out_tertiary;
		logic               last_out;
	} result_req_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		load_req_t item;
		logic      store;
	} sort_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} back_state_t;

endpackage

>>> design/tkds_front.sv
// Front end: accepts load requests, decides store or drop, counts the set.
`timescale 1ns / 1ps

module tkds_front #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_stall,
	input  tkds_pkg::load_req_t load_req,
	output logic                push_valid,
	input  logic                push_stall,
	output tkds_pkg::sort_cmd_t push_cmd
);
	import tkds_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] cnt_q;
	logic          room;
	logic          take;

	assign room       = cnt_q < CW'(MAX_ITEMS);
	assign load_stall = push_stall;
	assign take       = load_valid && !push_stall;

	assign push_valid     = load_valid;
	assign push_cmd.item  = load_req;
	assign push_cmd.store = room;

	// Count stored entries of the open set; a last request closes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (load_req.is_last) begin
				cnt_q <= '0;
			end else if (room) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

>>> design/tkds_queue.sv
// Short command queue that decouples the front end from the sorting back end.
`timescale 1ns / 1ps

module tkds_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_stall,
	input  tkds_pkg::sort_cmd_t push_cmd,
	output logic                pop_valid,
	input  logic                pop_stall,
	output tkds_pkg::sort_cmd_t pop_cmd
);
	import tkds_pkg::*;

	localparam int QPW = $clog2(Q_DEPTH);

	sort_cmd_t      slots_q [Q_DEPTH];
	logic [QPW:0]   wr_ptr_q;
	logic [QPW:0]   rd_ptr_q;
	logic           full;
	logic           empty;

	assign empty      = wr_ptr_q == rd_ptr_q;
	assign full       = (wr_ptr_q ^ rd_ptr_q) == {1'b1, {QPW{1'b0}}};
	assign push_stall = full;
	assign pop_valid  = !empty;
	assign pop_cmd    = slots_q[rd_ptr_q[QPW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (!empty && !pop_stall) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			slots_q[wr_ptr_q[QPW-1:0]] <= push_cmd;
		end
	end

endmodule

>>> design/tkds_back.sv
// Back end: entry memory, selection-sort scan and the result output register.
`timescale 1ns / 1ps

module tkds_back #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_stall,
	input  tkds_pkg::sort_cmd_t   pop_cmd,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tkds_pkg::result_req_t result_req
);
	import tkds_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = $clog2(MAX_ITEMS);

	typedef struct packed {
		logic [ID_WIDTH-1:0]  id;
		logic [KEY_WIDTH-1:0] k1;
		logic [KEY_WIDTH-1:0] k2;
		logic [KEY_WIDTH-1:0] k3;
	} ent_t;

	// Strictly greater in (k1, k2, k3), keys signed
	function automatic logic ranks_above(ent_t a, ent_t b);
		logic r;
		if (a.k1 != b.k1) begin
			r = $signed(a.k1) > $signed(b.k1);
		end else if (a.k2 != b.k2) begin
			r = $signed(a.k2) > $signed(b.k2);
		end else begin
			r = $signed(a.k3) > $signed(b.k3);
		end
		return r;
	endfunction

	ent_t                 mem [MAX_ITEMS];
	back_state_t          state_q;
	back_state_t          state_d;
	logic [CW-1:0]        wr_cnt_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        rd_cnt_q;
	logic [CW-1:0]        pos_q;
	logic [MAX_ITEMS-1:0] emitted_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	ent_t                 rd_data_s1;
	ent_t                 best_q;
	logic [IW-1:0]        best_idx_q;
	logic                 have_best_q;
	logic                 out_vld_q;
	result_req_t          out_q;
	ent_t                 wr_ent;
	logic                 we;
	logic                 issue;
	logic                 load_out;
	logic                 last_pos;
	logic                 take_best;

	assign wr_ent.id = ID_WIDTH'(pop_cmd.item.item_id);
	assign wr_ent.k1 = KEY_WIDTH'(pop_cmd.item.primary_weight);
	assign wr_ent.k2 = KEY_WIDTH'(pop_cmd.item.secondary_weight);
	assign wr_ent.k3 = KEY_WIDTH'(pop_cmd.item.tertiary_weight);

	assign pop_stall = state_q != ST_IDLE;
	assign last_pos  = (pos_q + 1'b1) == n_q;
	// Ascending scan with strict compare keeps the earliest of equal entries
	assign take_best = rd_vld_s1 && !emitted_q[rd_idx_s1]
	                   && (!have_best_q || ranks_above(rd_data_s1, best_q));

	assign result_valid = out_vld_q;
	assign result_req   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					we = pop_cmd.store;
					if (pop_cmd.item.is_last) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				issue = rd_cnt_q < n_q;
				if (!issue && !rd_vld_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				load_out = !out_vld_q || !result_stall;
				if (load_out) begin
					state_d = last_pos ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q    <= '0;
			n_q         <= '0;
			rd_cnt_q    <= '0;
			pos_q       <= '0;
			emitted_q   <= '0;
			rd_vld_s1   <= 1'b0;
			have_best_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// Hold a stalled result, drop an accepted one unless a new one loads
			out_vld_q <= load_out || (out_vld_q && result_stall);
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_cmd.item.is_last) begin
							n_q         <= wr_cnt_q + CW'(pop_cmd.store);
							wr_cnt_q    <= '0;
							rd_cnt_q    <= '0;
							pos_q       <= '0;
							emitted_q   <= '0;
							have_best_q <= 1'b0;
						end else if (pop_cmd.store) begin
							wr_cnt_q <= wr_cnt_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (take_best) begin
						have_best_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						emitted_q[best_idx_q]  <= 1'b1;
						pos_q                  <= pos_q + 1'b1;
						rd_cnt_q               <= '0;
						have_best_q            <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[IW-1:0];
		if (take_best) begin
			best_q     <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (load_out) begin
			out_q.sorted_id     <= 16'(best_q.id);
			out_q.out_primary   <= 32'($signed(best_q.k1));
			out_q.out_secondary <= 32'($signed(best_q.k2));
			out_q.out_tertiary  <= 32'($signed(best_q.k3));
			out_q.last_out      <= last_pos;
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_cnt_q[IW-1:0]] <= wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_cnt_q[IW-1:0]];
	end

	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> have_best_q)
		else $error("emit without a selected entry");

	a_emit_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !emitted_q[best_idx_q])
		else $error("selected entry was already emitted");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> wr_cnt_q < CW'(MAX_ITEMS))
		else $error("store write beyond capacity");

	a_pos_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> (n_q != '0 && pos_q < n_q))
		else $error("output position outside the set");

endmodule

>>> design/three_key_descending_sort.sv
// Top level of the three-key descending sorter: front, command queue, back.
`timescale 1ns / 1ps
// Load: the front and command queue take one request per cycle while the back
//   is idle; the back writes one entry per cycle into its memory.
// Sort: each result of a set of n entries takes a full scan over the n stored
//   entries and an emit step, which waits while a stalled result is held; the
//   set drains after n such scans, one result per scan.
// Reset: arst_n clears pointers, counts, flags and valid bits; memory is not cleared.

module three_key_descending_sort #(
	parameter int MAX_ITEMS = tkds_pkg::DEF_MAX_ITEMS,
	parameter int KEY_WIDTH = tkds_pkg::DEF_KEY_WIDTH,
	parameter int ID_WIDTH  = tkds_pkg::DEF_ID_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	output logic                  load_stall,
	input  tkds_pkg::load_req_t   load_req,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tkds_pkg::result_req_t result_req
);
	import tkds_pkg::*;

	// Front to queue
	logic      push_valid;
	logic      push_stall;
	sort_cmd_t push_cmd;

	// Queue to back
	logic      pop_valid;
	logic      pop_stall;
	sort_cmd_t pop_cmd;

	// Classify each request: store it while the set has room, drop it once
	// the set is full; a last request always passes to close the set.
	tkds_front #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_stall (load_stall),
		.load_req   (load_req),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_cmd   (push_cmd)
	);

	// Hold requests of the next set while the back is still sorting.
	tkds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_cmd    (pop_cmd)
	);

	// Store entries, then select the greatest unemitted entry per scan
	// (earliest arrival wins ties) and advance it into the output register.
	tkds_back #(
		.MAX_ITEMS (MAX_ITEMS),
		.KEY_WIDTH (KEY_WIDTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_stall    (pop_stall),
		.pop_cmd      (pop_cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_req   (result_req)
	);

endmodule
